@@ sv/png_scanline_unfilter_macros.svh @@
// assertion macros shared by the scanline unfilter rtl
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PSU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/psu_pkg.sv @@
// shared constants, types and predictor functions of the scanline unfilter
package psu_pkg;

  localparam int MAX_LINE_BYTES = 4096;
  localparam int MAX_BPP        = 8;
  localparam int LINE_AW        = (MAX_LINE_BYTES > 2) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int BPP_AW         = (MAX_BPP > 2) ? $clog2(MAX_BPP) : 1;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  // item held in the reconstruction stage
  typedef struct packed {
    logic [7:0]         data;
    logic [LINE_AW-1:0] col;
    filter_e            filt;
    logic               first_row;
    logic               row_end;
    logic               image_end;
    logic               bad;
  } s1_t;

  // clamp line width to 1..MAX_LINE_BYTES
  function automatic logic [LINE_AW:0] sat_width(input logic [12:0] lw);
    logic [LINE_AW:0] res;
    if (lw == 13'd0) begin
      res = (LINE_AW+1)'(1);
    end else if (int'(lw) > MAX_LINE_BYTES) begin
      res = (LINE_AW+1)'(MAX_LINE_BYTES);
    end else begin
      res = (LINE_AW+1)'(lw);
    end
    return res;
  endfunction

  // clamp bytes per pixel to 1..MAX_BPP
  function automatic logic [3:0] sat_bpp(input logic [3:0] bpp);
    logic [3:0] res;
    if (bpp == 4'd0) begin
      res = 4'd1;
    end else if (int'(bpp) > MAX_BPP) begin
      res = 4'(MAX_BPP);
    end else begin
      res = bpp;
    end
    return res;
  endfunction

  // paeth: nearest of a, b, c to a+b-c, ties to a then b
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] s;
    logic [9:0] c2;
    logic [7:0] res;
    pa = (b > c) ? 10'(b - c) : 10'(c - b);
    pb = (a > c) ? 10'(a - c) : 10'(c - a);
    s  = {2'b00, a} + {2'b00, b};
    c2 = {1'b0, c, 1'b0};
    pc = (s > c2) ? (s - c2) : (c2 - s);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

  function automatic logic [7:0] predict(input filter_e filt, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
    logic [8:0] sum;
    logic [7:0] res;
    sum = {1'b0, a} + {1'b0, b};
    case (filt)
      FILT_SUB:   res = a;
      FILT_UP:    res = b;
      FILT_AVG:   res = sum[8:1];
      FILT_PAETH: res = paeth(a, b, c);
      default:    res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

@@ sv/psu_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/png_scanline_unfilter.sv @@
// top level of the png scanline unfilter: stream decode, line buffer, byte reconstruction
//
// Undoes the per-row png filters (none, sub, up, average, paeth) on a byte stream.
// Each row is a filter-type byte followed by line_width data bytes; every data byte
// gives one reconstructed byte, and an unknown filter type gives one error item,
// after which input is dropped until a byte with image_start set. The row above the
// first row reads as zeros. Throughput is one input item per clock while in_stall_o
// is low: the line buffer is a synchronous ram whose read is issued from the column
// counter in the cycle an item is accepted, so the previous-row byte is ready when
// the item reaches the reconstruction stage. Data bytes and error items pass through
// the reconstruction stage, then the output register; filter bytes of a known type
// finish in the decode stage. The line buffer holds MAX_LINE_BYTES bytes, needs no
// clearing pass after reset, and its read data is used only in rows after the first.
// Configuration registers should be written only while no item is in flight.
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [psu_pkg::CFG_W-1:0]      cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           image_start_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     pixel_byte_o,
  output logic                           row_end_o,
  output logic                           image_end_o,
  output logic                           bad_filter_o,
  output logic [7:0]                     filter_code_o
);

  localparam int LAW = psu_pkg::LINE_AW;
  localparam int BAW = psu_pkg::BPP_AW;
  localparam int NB  = psu_pkg::MAX_BPP;

  // configuration registers
  logic [12:0] line_width_q;
  logic [3:0]  bpp_q;
  logic [15:0] row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= 13'd1;
      bpp_q        <= 4'd1;
      row_count_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        psu_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_data_i[12:0];
        psu_pkg::CFG_BPP:        bpp_q        <= cfg_data_i[3:0];
        psu_pkg::CFG_ROW_COUNT:  row_count_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [LAW:0] width_eff;
  logic [3:0]   bpp_eff;
  logic [15:0]  rows_eff;

  assign width_eff = psu_pkg::sat_width(line_width_q);
  assign bpp_eff   = psu_pkg::sat_bpp(bpp_q);
  assign rows_eff  = (row_count_q == 16'd0) ? 16'd1 : row_count_q;

  // ---------------------------------------------------------------------------
  // decode stage: stream position, filter type, error latch
  // ---------------------------------------------------------------------------
  logic [LAW-1:0]        column_q, column_d;
  logic [15:0]           row_idx_q, row_idx_d;
  psu_pkg::filter_e      filter_q, filter_d;
  logic                  expect_filt_q, expect_filt_d;
  logic                  first_row_q, first_row_d;
  logic                  error_q, error_d;

  // state as seen by this item, after an image start has taken effect
  logic [LAW-1:0]        col_e;
  logic [15:0]           row_e;
  psu_pkg::filter_e      filt_e;
  logic                  expect_e;
  logic                  first_e;
  logic                  err_e;

  logic                  in_acc;
  logic                  is_filt;
  logic                  is_bad;
  logic                  is_data;
  logic                  last_row;
  logic                  last_img;

  psu_pkg::s1_t          s1_q, s1_d;
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_load;
  logic                  s1_adv;

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    if (image_start_i) begin
      col_e    = '0;
      row_e    = '0;
      filt_e   = psu_pkg::FILT_NONE;
      expect_e = 1'b1;
      first_e  = 1'b1;
      err_e    = 1'b0;
    end else begin
      col_e    = column_q;
      row_e    = row_idx_q;
      filt_e   = filter_q;
      expect_e = expect_filt_q;
      first_e  = first_row_q;
      err_e    = error_q;
    end
  end

  assign is_filt  = !err_e && expect_e;
  assign is_bad   = is_filt && (data_byte_i > psu_pkg::FILT_MAX_CODE);
  assign is_data  = !err_e && !expect_e;
  assign last_row = ({1'b0, col_e} + (LAW+1)'(1)) >= width_eff;
  assign last_img = last_row && (({1'b0, row_e} + 17'd1) >= {1'b0, rows_eff});

  always_comb begin
    column_d      = col_e;
    row_idx_d     = row_e;
    filter_d      = filt_e;
    expect_filt_d = expect_e;
    first_row_d   = first_e;
    error_d       = err_e;
    if (is_bad) begin
      error_d = 1'b1;
    end else if (is_filt) begin
      filter_d      = psu_pkg::filter_e'(data_byte_i[2:0]);
      expect_filt_d = 1'b0;
      column_d      = '0;
    end else if (is_data) begin
      if (last_img) begin
        // image done, back to the state after an image start
        column_d      = '0;
        row_idx_d     = '0;
        filter_d      = psu_pkg::FILT_NONE;
        expect_filt_d = 1'b1;
        first_row_d   = 1'b1;
      end else if (last_row) begin
        column_d      = '0;
        row_idx_d     = row_e + 16'd1;
        first_row_d   = 1'b0;
        expect_filt_d = 1'b1;
      end else begin
        column_d = col_e + LAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= '0;
      row_idx_q     <= '0;
      filter_q      <= psu_pkg::FILT_NONE;
      expect_filt_q <= 1'b1;
      first_row_q   <= 1'b1;
      error_q       <= 1'b0;
    end else if (in_acc) begin
      column_q      <= column_d;
      row_idx_q     <= row_idx_d;
      filter_q      <= filter_d;
      expect_filt_q <= expect_filt_d;
      first_row_q   <= first_row_d;
      error_q       <= error_d;
    end
  end

  // only data bytes and error reports move on to the reconstruction stage
  assign s1_load = in_acc && (is_data || is_bad);

  always_comb begin
    s1_d.data      = data_byte_i;
    s1_d.col       = col_e;
    s1_d.filt      = filt_e;
    s1_d.first_row = first_e;
    s1_d.row_end   = is_data && last_row;
    s1_d.image_end = is_data && last_img;
    s1_d.bad       = is_bad;
  end

  // ---------------------------------------------------------------------------
  // line buffer: read at acceptance, written back from the reconstruction stage
  // ---------------------------------------------------------------------------
  logic           ram_re;
  logic           ram_we;
  logic [7:0]     ram_rdata;
  logic [7:0]     value;

  assign ram_re = in_acc && is_data;
  assign ram_we = s1_adv && !s1_q.bad;

  psu_ram #(
    .WIDTH (8),
    .DEPTH (psu_pkg::MAX_LINE_BYTES)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.col),
    .wdata_i (value),
    .re_i    (ram_re),
    .raddr_i (col_e),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // reconstruction stage
  // ---------------------------------------------------------------------------
  logic           out_valid_q;

  // stage moves when the output register is free or being emptied
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_d;
    end
  end

  // last bytes of this row and the previous-row bytes used with them
  logic [7:0]     left_hist_q [NB];
  logic [7:0]     up_hist_q   [NB];
  logic [BAW-1:0] hidx;
  logic           has_left;
  logic [7:0]     nb_a;
  logic [7:0]     nb_b;
  logic [7:0]     nb_c;
  logic [7:0]     pred;

  assign hidx     = BAW'(bpp_eff - 4'd1);
  assign has_left = s1_q.col >= LAW'(bpp_eff);
  assign nb_a     = has_left ? left_hist_q[hidx] : 8'd0;
  assign nb_b     = s1_q.first_row ? 8'd0 : ram_rdata;
  assign nb_c     = (has_left && !s1_q.first_row) ? up_hist_q[hidx] : 8'd0;
  assign pred     = psu_pkg::predict(s1_q.filt, nb_a, nb_b, nb_c);
  assign value    = s1_q.data + pred;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NB; k++) begin
        left_hist_q[k] <= 8'd0;
        up_hist_q[k]   <= 8'd0;
      end
    end else if (ram_we) begin
      left_hist_q[0] <= value;
      up_hist_q[0]   <= nb_b;
      for (int k = 1; k < NB; k++) begin
        left_hist_q[k] <= left_hist_q[k-1];
        up_hist_q[k]   <= up_hist_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [7:0] pixel_q;
  logic       row_end_q;
  logic       image_end_q;
  logic       bad_q;
  logic [7:0] code_q;
  logic       out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_q     <= s1_q.bad ? 8'd0 : value;
      row_end_q   <= s1_q.row_end;
      image_end_q <= s1_q.image_end;
      bad_q       <= s1_q.bad;
      code_q      <= s1_q.bad ? s1_q.data : 8'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_byte_o  = pixel_q;
  assign row_end_o     = row_end_q;
  assign image_end_o   = image_end_q;
  assign bad_filter_o  = bad_q;
  assign filter_code_o = code_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a filter byte always separates rows, so read and write never hit one entry
  `PSU_ASSERT_IMPL(a_no_ram_collision, ram_re && ram_we, s1_q.col != col_e,
                   "line buffer read and write to the same column")
  // a held reconstruction item keeps its line buffer data: no new read meanwhile
  `PSU_ASSERT_IMPL(a_no_read_while_held, s1_valid_q && !s1_adv, !ram_re,
                   "line buffer read while reconstruction stage is stalled")
  // once latched, the error drops everything until an image start
  `PSU_ASSERT_NEXT(a_error_drops_input, in_acc && error_q && !image_start_i, !s1_valid_q,
                   "item passed on while the error latch is set")
  // image end only on the last byte of a row, never on an error item
  `PSU_ASSERT_IMPL(a_image_end_on_row_end, out_valid_o && image_end_o,
                   row_end_o && !bad_filter_o,
                   "image end without row end")

endmodule

@@ verif/png_scanline_unfilter_tb.sv @@
// self-checking testbench of the png scanline unfilter: directed rows, then random images
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;

  localparam int SETTLE_CYCLES = 6;     // lets the reconstruction stage and output register drain, with margin
  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up

  // one result item as the block presents it
  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
    logic [7:0] code;
  } pix_t;

  localparam pix_t NO_PIX = '0;
  localparam logic [7:0] CODE_BAD_LOW = psu_pkg::FILT_MAX_CODE + 8'd1;

  // how a directed row is checked: no result, typed result, or computed result
  typedef enum logic [1:0] {
    ROW_QUIET,
    ROW_TYPED,
    ROW_MODEL
  } row_kind_e;

  typedef struct packed {
    logic [7:0] d;
    logic       s;
    row_kind_e  kind;
    pix_t       want;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [psu_pkg::CFG_W-1:0]     cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [7:0]                    data_byte_i;
  logic                          image_start_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [7:0]                    pixel_byte_o;
  logic                          row_end_o;
  logic                          image_end_o;
  logic                          bad_filter_o;
  logic [7:0]                    filter_code_o;

  png_scanline_unfilter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .image_start_i (image_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_byte_o  (pixel_byte_o),
    .row_end_o     (row_end_o),
    .image_end_o   (image_end_o),
    .bad_filter_o  (bad_filter_o),
    .filter_code_o (filter_code_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: registers as written, line buffer, histories, counters
  // ---------------------------------------------------------------------------
  logic [12:0]       line_reg;
  logic [3:0]        bpp_reg;
  logic [15:0]       rows_reg;
  logic [7:0]        line_mem [psu_pkg::MAX_LINE_BYTES];
  logic [7:0]        left_q [psu_pkg::MAX_BPP];        // last reconstructed bytes of this row
  logic [7:0]        above_left_q [psu_pkg::MAX_BPP];  // last previous-row bytes used
  int unsigned       col_q;
  int unsigned       row_q;
  psu_pkg::filter_e  filt_q;
  bit                want_filter;
  bit                first_row;
  bit                latched;       // unknown filter seen, waiting for image start
  bit                restart_due;   // new register set: next item opens a fresh image

  pix_t         pending_pixels [$];      // reconstructed bytes still to come out
  int unsigned  live_items;              // items the block does not just drop
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int unsigned  burst_left;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = line_reg;
    if (w == 0) begin
      w = 1;
    end else if (w > psu_pkg::MAX_LINE_BYTES) begin
      w = psu_pkg::MAX_LINE_BYTES;
    end
    return w;
  endfunction

  function automatic int unsigned eff_bpp();
    int unsigned n;
    n = bpp_reg;
    if (n == 0) begin
      n = 1;
    end else if (n > psu_pkg::MAX_BPP) begin
      n = psu_pkg::MAX_BPP;
    end
    return n;
  endfunction

  function automatic int unsigned eff_rows();
    return (rows_reg == 0) ? 1 : rows_reg;
  endfunction

  function automatic void clear_image_state();
    for (int k = 0; k < psu_pkg::MAX_BPP; k++) begin
      left_q[k]       = '0;
      above_left_q[k] = '0;
    end
    col_q       = 0;
    row_q       = 0;
    filt_q      = psu_pkg::FILT_NONE;
    want_filter = 1'b1;
    first_row   = 1'b1;
  endfunction

  // paeth choice via the distances to p = a + b - c, ties to a, then b
  function automatic int nearest_byte(input int a, input int b, input int c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) begin
      return a;
    end
    return (pb <= pc) ? b : c;
  endfunction

  // advance the predictor by one input item, tell whether it makes a result
  task automatic unfilter_byte(input logic [7:0] d, input logic s, output bit made,
                               output pix_t r);
    int unsigned w;
    int unsigned bpp;
    int unsigned col;
    int          a;
    int          b;
    int          c;
    int          guess;
    logic [7:0]  v;
    bit          last_row;
    bit          last_img;
    w    = eff_width();
    bpp  = eff_bpp();
    made = 1'b0;
    r    = NO_PIX;
    if (s) begin
      latched = 1'b0;
      clear_image_state();
    end
    if (latched) begin
      return;
    end
    if (want_filter) begin
      if (d > psu_pkg::FILT_MAX_CODE) begin
        // unknown filter: one error item, then drop everything until a start
        latched = 1'b1;
        made    = 1'b1;
        r.bad   = 1'b1;
        r.code  = d;
        return;
      end
      filt_q      = psu_pkg::filter_e'(d[2:0]);
      want_filter = 1'b0;
      col_q       = 0;
      for (int k = 0; k < psu_pkg::MAX_BPP; k++) begin
        left_q[k]       = '0;
        above_left_q[k] = '0;
      end
      return;
    end
    col = (col_q >= psu_pkg::MAX_LINE_BYTES) ? psu_pkg::MAX_LINE_BYTES - 1 : col_q;
    a = (col >= bpp) ? int'(left_q[bpp-1]) : 0;
    b = first_row ? 0 : int'(line_mem[col]);  // row above the first row is zero
    c = (col >= bpp && !first_row) ? int'(above_left_q[bpp-1]) : 0;
    case (filt_q)
      psu_pkg::FILT_SUB:   guess = a;
      psu_pkg::FILT_UP:    guess = b;
      psu_pkg::FILT_AVG:   guess = (a + b) / 2;
      psu_pkg::FILT_PAETH: guess = nearest_byte(a, b, c);
      default:             guess = 0;
    endcase
    v = 8'(int'(d) + guess);
    for (int k = psu_pkg::MAX_BPP - 1; k > 0; k--) begin
      left_q[k]       = left_q[k-1];
      above_left_q[k] = above_left_q[k-1];
    end
    left_q[0]       = v;
    above_left_q[0] = 8'(b);
    line_mem[col]   = v;
    // a width shrunk in mid-row ends the row at the current column
    last_row = (col + 1 >= w);
    last_img = last_row && (row_q + 1 >= eff_rows());
    if (last_img) begin
      clear_image_state();
    end else if (last_row) begin
      row_q       = (row_q + 1) & 16'hFFFF;
      first_row   = 1'b0;
      want_filter = 1'b1;
      col_q       = 0;
    end else begin
      col_q = col + 1;
    end
    made        = 1'b1;
    r.pixel     = v;
    r.row_end   = last_row;
    r.image_end = last_img;
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps, payload changes at negedge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input logic s, input row_kind_e kind,
                           input pix_t want);
    bit          made;
    pix_t        calc;
    int unsigned gap;
    logic        start;
    start = s;
    if (restart_due) begin
      start       = 1'b1;
      restart_due = 1'b0;
    end
    if (!(latched && !start)) begin
      live_items++;
    end
    unfilter_byte(d, start, made, calc);
    if (kind == ROW_TYPED) begin
      pending_pixels.push_back(want);
    end else if (kind == ROW_MODEL && made) begin
      pending_pixels.push_back(calc);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    data_byte_i   = d;
    image_start_i = start;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  // drop valid, wait for every expected item, then let the pipe run empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [psu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psu_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    case (idx)
      psu_pkg::CFG_LINE_WIDTH: line_reg = val[12:0];
      psu_pkg::CFG_BPP:        bpp_reg  = val[3:0];
      psu_pkg::CFG_ROW_COUNT:  rows_reg = val;
      default:                 ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // a new register set always begins with a fresh image, so a wider row never
  // reads line buffer columns that the running image did not write
  task automatic reconfigure(input logic [psu_pkg::CFG_W-1:0] lw,
                             input logic [psu_pkg::CFG_W-1:0] bpp,
                             input logic [psu_pkg::CFG_W-1:0] rows);
    settle();
    write_reg(psu_pkg::CFG_LINE_WIDTH, lw);
    write_reg(psu_pkg::CFG_BPP, bpp);
    write_reg(psu_pkg::CFG_ROW_COUNT, rows);
    restart_due = 1'b1;
  endtask

  // bias toward the extremes and small values, where paeth ties show up
  function automatic logic [7:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      return 8'h00;
    end else if (pick == 1) begin
      return 8'hFF;
    end else if (pick == 2) begin
      return 8'($urandom_range(0, 3));
    end
    return 8'($urandom);
  endfunction

  // well-formed images with random content, plus some broken sequences
  task automatic random_phase(input int unsigned budget, input int unsigned noise_pct);
    int unsigned stop_at;
    int unsigned rows_cap;
    int unsigned nrows;
    int unsigned w;
    stop_at = live_items + budget;
    while (live_items < stop_at) begin
      w = eff_width();
      if ($urandom_range(0, 99) < 3) begin
        settle();
      end
      if ($urandom_range(0, 99) >= noise_pct) begin
        rows_cap = (eff_rows() < 5) ? eff_rows() : 5;
        nrows = (rows_cap == eff_rows() && $urandom_range(0, 3) != 0) ?
                rows_cap : $urandom_range(1, rows_cap);
        for (int unsigned r = 0; r < nrows; r++) begin
          send_byte(8'($urandom_range(0, 4)), (r == 0) && ($urandom_range(0, 9) != 0),
                    ROW_MODEL, NO_PIX);
          for (int unsigned k = 0; k < w; k++) begin
            send_byte(rand_pixel(), 1'b0, ROW_MODEL, NO_PIX);
          end
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // unknown filter type followed by bytes that should be dropped
            send_byte(8'($urandom_range(5, 255)), 1'($urandom_range(0, 1)), ROW_MODEL,
                      NO_PIX);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0, ROW_MODEL, NO_PIX);
          end
          1: begin
            // image cut short in its first row
            send_byte(8'($urandom_range(0, 4)), 1'b1, ROW_MODEL, NO_PIX);
            repeat ($urandom_range(0, w - 1)) send_byte(rand_pixel(), 1'b0, ROW_MODEL, NO_PIX);
          end
          default: begin
            repeat ($urandom_range(1, 6)) begin
              send_byte(8'($urandom), $urandom_range(0, 7) == 0, ROW_MODEL, NO_PIX);
            end
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern in spans, from never stalling to stalling most cycles
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned span;
    int unsigned pct;
    out_stall_i = 1'b0;
    forever begin
      span = $urandom_range(8, 64);
      pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 85);
      repeat (span) begin
        @(negedge clk_i);
        out_stall_i = ($urandom_range(0, 99) < pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: oldest expectation against each accepted result item
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    pix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: result item with none expected, got pixel %0h bad %0b code %0h",
                 $time, pixel_byte_o, bad_filter_o, filter_code_o);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_byte", want.pixel, pixel_byte_o);
        check_field("row_end", 8'(want.row_end), 8'(row_end_o));
        check_field("image_end", 8'(want.image_end), 8'(image_end_o));
        check_field("bad_filter", 8'(want.bad), 8'(bad_filter_o));
        check_field("filter_code", want.code, filter_code_o);
      end
    end
  end

  // watchdog: count cycles in which neither side moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  dir_row_t opening_rows [22];

  initial begin : stimulus
    cfg_we_i      = 1'b0;
    cfg_index_i   = psu_pkg::CFG_LINE_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    image_start_i = 1'b0;
    rst_ni        = 1'b0;
    quiet_cycles  = 0;
    live_items    = 0;
    mismatches    = 0;
    burst_left    = 0;
    line_reg      = 13'd1;
    bpp_reg       = 4'd1;
    rows_reg      = 16'd1;
    latched       = 1'b0;
    restart_due   = 1'b0;
    for (int k = 0; k < psu_pkg::MAX_LINE_BYTES; k++) begin
      line_mem[k] = '0;
    end
    clear_image_state();

    // register values after reset: one byte per row, one row per image
    opening_rows = '{
      '{8'(psu_pkg::FILT_NONE),  1'b1, ROW_QUIET, NO_PIX},
      '{8'hFF,          1'b0, ROW_TYPED, '{8'hFF, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{8'(psu_pkg::FILT_SUB),   1'b0, ROW_QUIET, NO_PIX},  // image end, so a new filter
      '{8'h00,          1'b0, ROW_TYPED, '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{8'(psu_pkg::FILT_UP),    1'b0, ROW_QUIET, NO_PIX},
      '{8'h80,          1'b0, ROW_TYPED, '{8'h80, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{8'(psu_pkg::FILT_AVG),   1'b0, ROW_QUIET, NO_PIX},
      '{8'h7F,          1'b0, ROW_TYPED, '{8'h7F, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{8'(psu_pkg::FILT_PAETH), 1'b0, ROW_QUIET, NO_PIX},
      '{8'h01,          1'b0, ROW_TYPED, '{8'h01, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{CODE_BAD_LOW,   1'b0, ROW_TYPED, '{8'h00, 1'b0, 1'b0, 1'b1, CODE_BAD_LOW}},
      '{8'(psu_pkg::FILT_UP),    1'b0, ROW_QUIET, NO_PIX},  // dropped while latched
      '{8'hFF,          1'b0, ROW_QUIET, NO_PIX},
      '{8'hFF,          1'b1, ROW_TYPED, '{8'h00, 1'b0, 1'b0, 1'b1, 8'hFF}},
      '{8'h80,          1'b1, ROW_TYPED, '{8'h00, 1'b0, 1'b0, 1'b1, 8'h80}},
      '{8'(psu_pkg::FILT_SUB),   1'b1, ROW_QUIET, NO_PIX},
      '{8'(psu_pkg::FILT_AVG),   1'b1, ROW_QUIET, NO_PIX},  // start again before any data
      '{8'h5A,          1'b0, ROW_MODEL, NO_PIX},
      '{8'(psu_pkg::FILT_NONE),  1'b1, ROW_QUIET, NO_PIX},
      '{8'h55,          1'b1, ROW_TYPED, '{8'h00, 1'b0, 1'b0, 1'b1, 8'h55}},  // start on data
      '{8'(psu_pkg::FILT_PAETH), 1'b1, ROW_QUIET, NO_PIX},
      '{8'hAA,          1'b0, ROW_MODEL, NO_PIX}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (opening_rows[i]) begin
      send_byte(opening_rows[i].d, opening_rows[i].s, opening_rows[i].kind,
                opening_rows[i].want);
    end

    // random images over a spread of settings, clamped values among them
    reconfigure(16'd3, 16'd1, 16'd2);
    random_phase(150, 15);
    reconfigure(16'd5, 16'd3, 16'd3);
    random_phase(150, 15);
    reconfigure(16'd16, 16'd8, 16'd2);
    random_phase(150, 15);
    reconfigure(16'd0, 16'd0, 16'd0);        // all three clamp up to one
    random_phase(100, 15);
    reconfigure(16'd6, 16'd15, 16'd4);       // bytes per pixel clamps to eight
    random_phase(150, 15);
    reconfigure(16'd2, 16'd2, 16'hFFFF);     // images that never reach their end
    random_phase(120, 15);

    // width shrunk in the middle of a row: the row ends at the next byte
    reconfigure(16'd9, 16'd4, 16'd3);
    send_byte(8'(psu_pkg::FILT_PAETH), 1'b1, ROW_MODEL, NO_PIX);
    repeat (9) send_byte(rand_pixel(), 1'b0, ROW_MODEL, NO_PIX);
    send_byte(8'(psu_pkg::FILT_AVG), 1'b0, ROW_MODEL, NO_PIX);
    repeat (4) send_byte(rand_pixel(), 1'b0, ROW_MODEL, NO_PIX);
    settle();
    write_reg(psu_pkg::CFG_LINE_WIDTH, 16'd3);
    write_reg(psu_pkg::CFG_BPP, 16'd1);
    send_byte(rand_pixel(), 1'b0, ROW_MODEL, NO_PIX);
    send_byte(8'(psu_pkg::FILT_PAETH), 1'b0, ROW_MODEL, NO_PIX);
    repeat (3) send_byte(rand_pixel(), 1'b0, ROW_MODEL, NO_PIX);
    random_phase(150, 15);

    reconfigure(16'd1, 16'd8, 16'd5);
    random_phase(100, 15);
    // widest rows, all width and bpp register bits set: the start of a first row only
    reconfigure(16'hFFFF, 16'hFFFF, 16'd1);
    send_byte(8'(psu_pkg::FILT_PAETH), 1'b1, ROW_MODEL, NO_PIX);
    repeat (40) send_byte(rand_pixel(), 1'b0, ROW_MODEL, NO_PIX);

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/psu_pkg.sv
sv/psu_ram.sv
sv/png_scanline_unfilter.sv
verif/png_scanline_unfilter_tb.sv
